[rtl/svsd_pkg.sv]
// Shared types and constants for the servo status reply deframer.
// No dependencies; imported by the parser, emitter, checker and top level.
package svsd_pkg;

    localparam int unsigned DATA_MAX_DEF = 32;
    localparam int unsigned CMD_DEPTH    = 2;
    localparam int unsigned OUT_DEPTH    = 4;

    localparam logic [7:0]  HDR_BYTE     = 8'hFF;
    localparam int unsigned MIN_FRAME    = 6;
    localparam int unsigned LEN_MIN      = 2;
    localparam int unsigned LEN_OVERHEAD = 4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FAULT    = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_HEADER   = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;

    // Verdict handed from the parser to the emitter.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] servo_id;
        logic [7:0] servo_error;
        logic [7:0] data_count;
        logic [5:0] copy_count;
    } cmd_t;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] servo_id;
        logic [7:0] servo_error;
        logic [7:0] data_count;
        logic       data_valid;
        logic [5:0] data_index;
        logic [7:0] data_byte;
        logic       is_last;
    } result_t;

endpackage

[rtl/svsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/svsd_fifo.sv]
// Small register FIFO used for the verdict queue and the result buffer.
// No dependencies.
module svsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full,
    output logic [CW-1:0]    count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;

endmodule

[rtl/svsd_front.sv]
// Byte parser: tracks the frame, stores payload bytes, issues one verdict per frame.
// Depends on svsd_pkg.
module svsd_front
    import svsd_pkg::*;
#(
    parameter int DATA_MAX = DATA_MAX_DEF,
    localparam int AW = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          kind,
    input  logic [7:0]    rx_byte,
    output logic          cmd_push,
    output cmd_t          cmd_data,
    input  logic          cmd_full,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    input  logic          ram_release
);

    logic [8:0] pos_reg, pos_next;
    logic       done_reg, done_next;
    logic       hdr_bad_reg, hdr_bad_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] err_reg, err_next;
    logic [7:0] sum_reg, sum_next;
    logic       ram_busy_reg, ram_busy_next;
    logic       accept;
    logic [8:0] data_pos;
    logic [8:0] cks_pos;
    logic [7:0] ndata;
    logic [5:0] copy_n;

    // Hold off input while the verdict queue is full, and new frames while the emitter still reads the last payload.
    assign full   = cmd_full || (ram_busy_reg && !done_reg);
    assign accept = push && !full;

    assign data_pos = 9'(pos_reg - 9'(MIN_FRAME - 1));
    assign cks_pos  = 9'(9'(len_reg) + 9'(LEN_OVERHEAD - 1));
    assign ndata    = 8'(len_reg - 8'(LEN_MIN));
    assign copy_n   = (ndata < 8'(DATA_MAX)) ? ndata[5:0] : 6'(DATA_MAX);

    always_comb
    begin
        pos_next      = pos_reg;
        done_next     = done_reg;
        hdr_bad_next  = hdr_bad_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        err_next      = err_reg;
        sum_next      = sum_reg;
        ram_busy_next = ram_busy_reg;
        cmd_push      = 1'b0;
        cmd_data      = '0;
        ram_we        = 1'b0;
        ram_waddr     = data_pos[AW-1:0];
        ram_wdata     = rx_byte;

        if (ram_release)
        begin
            ram_busy_next = 1'b0;
        end

        if (accept)
        begin
            if (kind == KIND_END)
            begin
                if (!done_reg)
                begin
                    cmd_push        = 1'b1;
                    cmd_data.status = ST_SHORT;
                end
                pos_next     = '0;
                done_next    = 1'b0;
                hdr_bad_next = 1'b0;
                id_next      = '0;
                len_next     = '0;
                err_next     = '0;
                sum_next     = '0;
            end
            else if (!done_reg)
            begin
                pos_next = 9'(pos_reg + 9'd1);
                if (pos_reg < 9'd2)
                begin
                    if (rx_byte != HDR_BYTE)
                    begin
                        hdr_bad_next = 1'b1;
                    end
                end
                else if (pos_reg < 9'(MIN_FRAME - 1))
                begin
                    if (pos_reg == 9'd2)
                    begin
                        id_next = rx_byte;
                    end
                    else if (pos_reg == 9'd3)
                    begin
                        len_next = rx_byte;
                    end
                    else
                    begin
                        err_next = rx_byte;
                    end
                    sum_next = 8'(sum_reg + rx_byte);
                end
                else if (pos_reg == 9'(MIN_FRAME - 1) &&
                         (hdr_bad_reg || len_reg < 8'(LEN_MIN)))
                begin
                    done_next       = 1'b1;
                    cmd_push        = 1'b1;
                    cmd_data.status = hdr_bad_reg ? ST_HEADER : ST_SHORT;
                end
                else if (pos_reg == cks_pos)
                begin
                    done_next = 1'b1;
                    cmd_push  = 1'b1;
                    if (~sum_reg != rx_byte)
                    begin
                        cmd_data.status = ST_CHECKSUM;
                    end
                    else
                    begin
                        cmd_data.status      = (err_reg != '0) ? ST_FAULT : ST_OK;
                        cmd_data.servo_id    = id_reg;
                        cmd_data.servo_error = err_reg;
                        cmd_data.data_count  = ndata;
                        cmd_data.copy_count  = copy_n;
                        if (copy_n != '0)
                        begin
                            ram_busy_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (data_pos < 9'(DATA_MAX))
                    begin
                        ram_we = 1'b1;
                    end
                    sum_next = 8'(sum_reg + rx_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            done_reg     <= 1'b0;
            hdr_bad_reg  <= 1'b0;
            id_reg       <= '0;
            len_reg      <= '0;
            err_reg      <= '0;
            sum_reg      <= '0;
            ram_busy_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            done_reg     <= done_next;
            hdr_bad_reg  <= hdr_bad_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            err_reg      <= err_next;
            sum_reg      <= sum_next;
            ram_busy_reg <= ram_busy_next;
        end
    end

endmodule

[rtl/svsd_back.sv]
// Emitter: expands each verdict into result words, reading payload from the RAM.
// Depends on svsd_pkg.
module svsd_back
    import svsd_pkg::*;
#(
    parameter int DATA_MAX = DATA_MAX_DEF,
    localparam int AW = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1,
    localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  cmd_t           cmd_head,
    output logic           cmd_pop,
    output logic           ram_re,
    output logic [AW-1:0]  ram_raddr,
    input  logic [7:0]     ram_rdata,
    output logic           ram_release,
    output logic           out_push,
    output result_t        out_data,
    input  logic [OCW-1:0] out_count
);

    logic       active_reg, active_next;
    cmd_t       cur_reg, cur_next;
    logic [5:0] idx_reg, idx_next;
    logic       s1_valid_reg;
    result_t    s1_item_reg, s1_item_next;
    cmd_t       src;
    logic [5:0] src_idx;
    logic       can_issue, issue, has_data, last;

    // Leave room in the result buffer for the word still in the read stage.
    assign can_issue = (OCW'(out_count) + OCW'(s1_valid_reg)) < OCW'(OUT_DEPTH);

    assign src      = active_reg ? cur_reg : cmd_head;
    assign src_idx  = active_reg ? idx_reg : '0;
    assign issue    = (active_reg || !cmd_empty) && can_issue;
    assign has_data = (src.copy_count != '0);
    assign last     = !has_data || (7'(src_idx) + 7'd1 == 7'(src.copy_count));

    assign cmd_pop     = issue && !active_reg;
    assign ram_re      = issue && has_data;
    assign ram_raddr   = src_idx[AW-1:0];
    assign ram_release = issue && has_data && last;

    always_comb
    begin
        active_next  = active_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        s1_item_next = s1_item_reg;
        if (issue)
        begin
            s1_item_next.status      = src.status;
            s1_item_next.servo_id    = src.servo_id;
            s1_item_next.servo_error = src.servo_error;
            s1_item_next.data_count  = src.data_count;
            s1_item_next.data_valid  = has_data;
            s1_item_next.data_index  = has_data ? src_idx : '0;
            s1_item_next.data_byte   = '0;
            s1_item_next.is_last     = last;
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
                cur_next    = src;
                idx_next    = 6'(src_idx + 6'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        s1_item_reg <= s1_item_next;
    end

    // Merge the registered RAM data into the word as it enters the buffer.
    always_comb
    begin
        out_data = s1_item_reg;
        if (s1_item_reg.data_valid)
        begin
            out_data.data_byte = ram_rdata;
        end
    end

    assign out_push = s1_valid_reg;

endmodule

[rtl/servo_status_reply_deframer_unit.sv]
// Top level of the servo status reply deframer: parser, verdict queue, emitter,
// payload RAM and result buffer. Depends on svsd_pkg, svsd_front, svsd_fifo, svsd_ram and svsd_back.
//
//   channel  | handshake          | words
//   ---------+--------------------+-----------------------------------------------
//   input    | push / full        | kind, rx_byte
//   result   | empty / pop        | status, servo_id, servo_error, data_count,
//            |                    | data_valid, data_index, data_byte, is_last
//
// The parser takes one input word per cycle while full is low. A verdict becomes
// 1 result word, or one word per copied payload byte, leaving at one word per cycle
// while the result buffer has room; the RAM's single read port and registered read
// set that pace. The first word passes the verdict queue, read stage and result buffer.
// While a payload is still being read out, a new frame's bytes are held off (full high).
// Reset is asynchronous; it clears the parser, queues and emitter; no RAM sweep.
module servo_status_reply_deframer_unit
    import svsd_pkg::*;
#(
    parameter int DATA_MAX = DATA_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] status,
    output logic [7:0] servo_id,
    output logic [7:0] servo_error,
    output logic [7:0] data_count,
    output logic       data_valid,
    output logic [5:0] data_index,
    output logic [7:0] data_byte,
    output logic       is_last
);

    localparam int AW   = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
    localparam int CCW  = $clog2(CMD_DEPTH + 1);
    localparam int OCW  = $clog2(OUT_DEPTH + 1);
    localparam int CMDW = $bits(cmd_t);
    localparam int OUTW = $bits(result_t);

    // Parser to verdict queue
    logic           cmd_push;
    cmd_t           cmd_wdata;
    logic           cmd_full;
    logic           cmd_empty;
    logic           cmd_pop;
    cmd_t           cmd_head;
    logic [CCW-1:0] cmd_count;

    // Payload RAM
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;
    logic           ram_release;

    // Emitter to result buffer
    logic           out_push;
    result_t        out_wdata;
    result_t        out_head;
    logic           out_full;
    logic [OCW-1:0] out_count;

    svsd_front #(
        .DATA_MAX(DATA_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_wdata),
        .cmd_full   (cmd_full),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_release(ram_release)
    );

    // Verdict queue: lets the parser run ahead of the emitter; a new frame's bytes still wait while a payload is read.
    svsd_fifo #(
        .WIDTH(CMDW),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_wdata),
        .rd_en  (cmd_pop),
        .rd_data(cmd_head),
        .empty  (cmd_empty),
        .full   (cmd_full),
        .count  (cmd_count)
    );

    svsd_ram #(
        .WIDTH(8),
        .DEPTH(DATA_MAX)
    ) u_payload (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    svsd_back #(
        .DATA_MAX(DATA_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .ram_release(ram_release),
        .out_push   (out_push),
        .out_data   (out_wdata),
        .out_count  (out_count)
    );

    // Result buffer: the emitter reserves space, so a push never meets a full buffer.
    svsd_fifo #(
        .WIDTH(OUTW),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (out_push),
        .wr_data(out_wdata),
        .rd_en  (pop),
        .rd_data(out_head),
        .empty  (empty),
        .full   (out_full),
        .count  (out_count)
    );

    assign status      = out_head.status;
    assign servo_id    = out_head.servo_id;
    assign servo_error = out_head.servo_error;
    assign data_count  = out_head.data_count;
    assign data_valid  = out_head.data_valid;
    assign data_index  = out_head.data_index;
    assign data_byte   = out_head.data_byte;
    assign is_last     = out_head.is_last;

endmodule

[rtl/svsd_checker.sv]
// Port-level checks on the deframer's result side, bound to the top level.
// Depends on svsd_pkg and servo_status_reply_deframer_unit.
module svsd_checker
    import svsd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] status,
    input logic [7:0] servo_id,
    input logic [7:0] servo_error,
    input logic [7:0] data_count,
    input logic       data_valid,
    input logic [5:0] data_index,
    input logic [7:0] data_byte,
    input logic       is_last
);

    // Failure verdicts are a single word with no payload.
    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK && status != ST_FAULT) |-> (is_last && !data_valid))
        else $error("failure verdict carries payload or is not last");

    // Payload words only follow a good checksum, and stay inside the count.
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && data_valid) |-> ((status == ST_OK || status == ST_FAULT) &&
                                    (8'(data_index) < data_count)))
        else $error("payload word with bad status or index");

    // Fault status tracks the reported error byte.
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_OK || status == ST_FAULT)) |->
            ((status == ST_FAULT) == (servo_error != 8'd0)))
        else $error("fault status disagrees with error byte");

    // A waiting word's byte, status, id and last flag hold until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(status) &&
                              $stable(servo_id) && $stable(is_last)))
        else $error("result word changed while stalled");

endmodule

bind servo_status_reply_deframer_unit svsd_checker u_svsd_checker (.*);
